// ----- hw/rtl/scr_pkg.sv -----
// Shared constants for the segment rectangle clipper.
// No dependencies; imported by segment_rectangle_clipper.
package scr_pkg;

    localparam int CFG_INDEX_W = 2;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_RECT_LOW_X  = 2'd0;
    localparam cfg_index_t REG_RECT_LOW_Y  = 2'd1;
    localparam cfg_index_t REG_RECT_HIGH_X = 2'd2;
    localparam cfg_index_t REG_RECT_HIGH_Y = 2'd3;

    // Reset edges, taken to the coordinate width by truncation
    localparam logic signed [63:0] RECT_LOW_RESET  = -(64'sd1 <<< 31);
    localparam logic signed [63:0] RECT_HIGH_RESET = (64'sd1 <<< 31) - 64'sd1;

endpackage

// ----- hw/rtl/scr_axis.sv -----
// Clips the stop point against the low and high sides of one axis.
// Pipelined: side select, multiply, one restoring-division bit per stage, rebuild.
// Depends on nothing but its parameters.
module scr_axis #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] sa,
    input  logic signed [W-1:0] sb,
    input  logic signed [W-1:0] pa,
    input  logic signed [W-1:0] pb,
    input  logic signed [W-1:0] edge_lo,
    input  logic signed [W-1:0] edge_hi,
    input  logic [SW-1:0]       side_in,
    output logic                out_valid,
    output logic signed [W-1:0] sa_o,
    output logic signed [W-1:0] sb_o,
    output logic signed [W-1:0] pa_o,
    output logic signed [W-1:0] pb_o,
    output logic [F:0]          frac_o,
    output logic [SW-1:0]       side_o
);

    // Quotient bits per division, numerator width
    localparam int S  = (W > F) ? W + 1 : F + 1;
    localparam int NW = S + W + 1;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [W+1:0] div_step(input logic [W:0] r, input logic b,
                                              input logic [W:0] d);
        logic [W+1:0] t;
        logic [W+1:0] dx;
        logic [W+1:0] diff;
        t    = {r, b};
        dx   = {1'b0, d};
        diff = t - dx;
        if (t >= dx)
            div_step = {1'b1, diff[W:0]};
        else
            div_step = {1'b0, t[W:0]};
    endfunction

    // ---------------- stage 0: pick the side, form in, out, den ----------------
    logic signed [W+1:0] out_lo, in_lo, out_hi, in_hi, out_s, in_s, da, db, na, nb;
    logic                cut_lo, cut_c;
    logic [W:0]          in_u, den_c, maga_c, magb_c;

    always_comb
    begin
        out_lo = (W+2)'(edge_lo) - (W+2)'(pa);
        in_lo  = (W+2)'(sa) - (W+2)'(edge_lo);
        out_hi = (W+2)'(pa) - (W+2)'(edge_hi);
        in_hi  = (W+2)'(edge_hi) - (W+2)'(sa);
        cut_lo = out_lo > 0;
        out_s  = cut_lo ? out_lo : out_hi;
        in_s   = cut_lo ? in_lo : in_hi;
        cut_c  = cut_lo || (out_hi > 0);
        in_u   = in_s[W+1] ? '0 : in_s[W:0];
        den_c  = in_u + out_s[W:0];
        da     = (W+2)'(pa) - (W+2)'(sa);
        db     = (W+2)'(pb) - (W+2)'(sb);
        na     = -da;
        nb     = -db;
        maga_c = da[W+1] ? na[W:0] : da[W:0];
        magb_c = db[W+1] ? nb[W:0] : db[W:0];
    end

    logic                s0_v_reg;
    logic                s0_cut_reg, s0_nega_reg, s0_negb_reg;
    logic signed [W-1:0] s0_sa_reg, s0_sb_reg, s0_pa_reg, s0_pb_reg;
    logic [W:0]          s0_in_reg, s0_den_reg, s0_maga_reg, s0_magb_reg;
    logic [SW-1:0]       s0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (en)
            s0_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_cut_reg  <= cut_c;
            s0_nega_reg <= da[W+1];
            s0_negb_reg <= db[W+1];
            s0_sa_reg   <= sa;
            s0_sb_reg   <= sb;
            s0_pa_reg   <= pa;
            s0_pb_reg   <= pb;
            s0_in_reg   <= in_u;
            s0_den_reg  <= den_c;
            s0_maga_reg <= maga_c;
            s0_magb_reg <= magb_c;
            s0_side_reg <= side_in;
        end
    end

    // ---------------- stage 1: products and scaled fraction numerator ----------------
    logic [2*W+1:0] proda_c, prodb_c;
    logic [NW-1:0]  numa_c, numb_c, numf_c;

    always_comb
    begin
        proda_c = (2*W+2)'(s0_maga_reg) * (2*W+2)'(s0_in_reg);
        prodb_c = (2*W+2)'(s0_magb_reg) * (2*W+2)'(s0_in_reg);
        numa_c  = NW'(proda_c);
        numb_c  = NW'(prodb_c);
        numf_c  = NW'(s0_in_reg) << F;
    end

    // Division pipeline; index 0 is the stage 1 register
    logic                v_reg    [0:S];
    logic                cut_reg  [0:S];
    logic                nega_reg [0:S];
    logic                negb_reg [0:S];
    logic signed [W-1:0] sa_reg   [0:S];
    logic signed [W-1:0] sb_reg   [0:S];
    logic signed [W-1:0] pa_reg   [0:S];
    logic signed [W-1:0] pb_reg   [0:S];
    logic [W:0]          den_reg  [0:S];
    logic [SW-1:0]       side_reg [0:S];
    logic [W:0]          rema_reg [0:S];
    logic [W:0]          remb_reg [0:S];
    logic [W:0]          remf_reg [0:S];
    logic [S-1:0]        lowa_reg [0:S];
    logic [S-1:0]        lowb_reg [0:S];
    logic [S-1:0]        lowf_reg [0:S];
    logic [S-1:0]        qa_reg   [0:S];
    logic [S-1:0]        qb_reg   [0:S];
    logic [S-1:0]        qf_reg   [0:S];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= s0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cut_reg[0]  <= s0_cut_reg;
            nega_reg[0] <= s0_nega_reg;
            negb_reg[0] <= s0_negb_reg;
            sa_reg[0]   <= s0_sa_reg;
            sb_reg[0]   <= s0_sb_reg;
            pa_reg[0]   <= s0_pa_reg;
            pb_reg[0]   <= s0_pb_reg;
            den_reg[0]  <= s0_den_reg;
            side_reg[0] <= s0_side_reg;
            rema_reg[0] <= numa_c[NW-1:S];
            remb_reg[0] <= numb_c[NW-1:S];
            remf_reg[0] <= numf_c[NW-1:S];
            lowa_reg[0] <= numa_c[S-1:0];
            lowb_reg[0] <= numb_c[S-1:0];
            lowf_reg[0] <= numf_c[S-1:0];
            qa_reg[0]   <= '0;
            qb_reg[0]   <= '0;
            qf_reg[0]   <= '0;
        end
    end

    // ---------------- division stages: one quotient bit each ----------------
    for (genvar k = 0; k < S; k++)
    begin : g_div
        logic [W+1:0] sta, stb, stf;
        logic [S-1:0] qa_n, qb_n, qf_n;

        always_comb
        begin
            sta  = div_step(rema_reg[k], lowa_reg[k][S-1-k], den_reg[k]);
            stb  = div_step(remb_reg[k], lowb_reg[k][S-1-k], den_reg[k]);
            stf  = div_step(remf_reg[k], lowf_reg[k][S-1-k], den_reg[k]);
            qa_n = qa_reg[k];
            qb_n = qb_reg[k];
            qf_n = qf_reg[k];
            qa_n[S-1-k] = sta[W+1];
            qb_n[S-1-k] = stb[W+1];
            qf_n[S-1-k] = stf[W+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cut_reg[k+1]  <= cut_reg[k];
                nega_reg[k+1] <= nega_reg[k];
                negb_reg[k+1] <= negb_reg[k];
                sa_reg[k+1]   <= sa_reg[k];
                sb_reg[k+1]   <= sb_reg[k];
                pa_reg[k+1]   <= pa_reg[k];
                pb_reg[k+1]   <= pb_reg[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
                rema_reg[k+1] <= sta[W:0];
                remb_reg[k+1] <= stb[W:0];
                remf_reg[k+1] <= stf[W:0];
                lowa_reg[k+1] <= lowa_reg[k];
                lowb_reg[k+1] <= lowb_reg[k];
                lowf_reg[k+1] <= lowf_reg[k];
                qa_reg[k+1]   <= qa_n;
                qb_reg[k+1]   <= qb_n;
                qf_reg[k+1]   <= qf_n;
            end
        end
    end

    // ---------------- final stage: rebuild the moved point ----------------
    logic [W+1:0]        qa_w, qb_w;
    logic signed [W+1:0] sga, sgb, resa, resb;
    logic [F:0]          frac_c;

    always_comb
    begin
        qa_w   = (W+2)'(qa_reg[S]);
        qb_w   = (W+2)'(qb_reg[S]);
        sga    = nega_reg[S] ? -$signed(qa_w) : $signed(qa_w);
        sgb    = negb_reg[S] ? -$signed(qb_w) : $signed(qb_w);
        resa   = (W+2)'(sa_reg[S]) + sga;
        resb   = (W+2)'(sb_reg[S]) + sgb;
        frac_c = cut_reg[S] ? qf_reg[S][F:0] : (F+1)'(1) << F;
    end

    logic                fin_v_reg;
    logic signed [W-1:0] fin_sa_reg, fin_sb_reg, fin_pa_reg, fin_pb_reg;
    logic [F:0]          fin_frac_reg;
    logic [SW-1:0]       fin_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_v_reg <= 1'b0;
        else if (en)
            fin_v_reg <= v_reg[S];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_sa_reg   <= sa_reg[S];
            fin_sb_reg   <= sb_reg[S];
            fin_pa_reg   <= cut_reg[S] ? resa[W-1:0] : pa_reg[S];
            fin_pb_reg   <= cut_reg[S] ? resb[W-1:0] : pb_reg[S];
            fin_frac_reg <= frac_c;
            fin_side_reg <= side_reg[S];
        end
    end

    assign out_valid = fin_v_reg;
    assign sa_o      = fin_sa_reg;
    assign sb_o      = fin_sb_reg;
    assign pa_o      = fin_pa_reg;
    assign pb_o      = fin_pb_reg;
    assign frac_o    = fin_frac_reg;
    assign side_o    = fin_side_reg;

endmodule

// ----- hw/rtl/segment_rectangle_clipper.sv -----
// Segment clipper top level: rectangle registers, x and y axis pipelines, fraction product.
// Depends on scr_pkg and scr_axis.
//
// Takes one segment beat per clock and returns one result beat per clock in order while
// the output beat is taken. The depth is set by the restoring dividers, one quotient bit
// per stage, in each of the two axis pipelines. The whole pipeline advances together and
// holds while the output beat is not taken. Write the rectangle registers only while no
// segment is in flight.
module segment_rectangle_clipper #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  scr_pkg::cfg_index_t           cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] stop_x,
    input  logic signed [COORD_WIDTH-1:0] stop_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] clipped_x,
    output logic signed [COORD_WIDTH-1:0] clipped_y,
    output logic [FRAC_BITS:0]            kept_fraction
);

    import scr_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;

    // Rectangle registers
    logic signed [W-1:0] rect_low_x_reg, rect_low_y_reg, rect_high_x_reg, rect_high_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_low_x_reg  <= RECT_LOW_RESET[W-1:0];
            rect_low_y_reg  <= RECT_LOW_RESET[W-1:0];
            rect_high_x_reg <= RECT_HIGH_RESET[W-1:0];
            rect_high_y_reg <= RECT_HIGH_RESET[W-1:0];
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RECT_LOW_X:  rect_low_x_reg  <= cfg_data;
                REG_RECT_LOW_Y:  rect_low_y_reg  <= cfg_data;
                REG_RECT_HIGH_X: rect_high_x_reg <= cfg_data;
                REG_RECT_HIGH_Y: rect_high_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output beat is held
    logic out_valid_reg;
    logic en;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // x sides first
    logic                xv;
    logic signed [W-1:0] x_sa, x_sb, x_pa, x_pb;
    logic [F:0]          fx;
    logic                x_side;

    scr_axis #(.W(W), .F(F), .SW(1)) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .sa       (start_x),
        .sb       (start_y),
        .pa       (stop_x),
        .pb       (stop_y),
        .edge_lo  (rect_low_x_reg),
        .edge_hi  (rect_high_x_reg),
        .side_in  (1'b0),
        .out_valid(xv),
        .sa_o     (x_sa),
        .sb_o     (x_sb),
        .pa_o     (x_pa),
        .pb_o     (x_pb),
        .frac_o   (fx),
        .side_o   (x_side)
    );

    // y sides on the moved stop point; carry fx alongside
    logic                yv;
    logic signed [W-1:0] y_sa, y_sb, y_pa, y_pb;
    logic [F:0]          fy, fx_d;

    scr_axis #(.W(W), .F(F), .SW(F+1)) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (xv),
        .sa       (x_sb),
        .sb       (x_sa),
        .pa       (x_pb),
        .pb       (x_pa),
        .edge_lo  (rect_low_y_reg),
        .edge_hi  (rect_high_y_reg),
        .side_in  (fx),
        .out_valid(yv),
        .sa_o     (y_sa),
        .sb_o     (y_sb),
        .pa_o     (y_pa),
        .pb_o     (y_pb),
        .frac_o   (fy),
        .side_o   (fx_d)
    );

    // Output stage: kept fraction is fx*fy scaled back by one
    logic [2*F+1:0]      fprod;
    logic signed [W-1:0] clipped_x_reg, clipped_y_reg;
    logic [F:0]          kept_reg;

    assign fprod = (2*F+2)'(fx_d) * (2*F+2)'(fy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= yv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clipped_x_reg <= y_pb;
            clipped_y_reg <= y_pa;
            kept_reg      <= fprod[2*F:F];
        end
    end

    assign out_valid     = out_valid_reg;
    assign clipped_x     = clipped_x_reg;
    assign clipped_y     = clipped_y_reg;
    assign kept_fraction = kept_reg;

    // Start points and the x side tag pass through only for reference; fold them into nothing
    logic unused_starts;
    assign unused_starts = ^{y_sa, y_sb, x_side};

endmodule
